// ===== hw/rtl/fcw_pkg.sv =====
`default_nettype none
package fcw_pkg;

	localparam int FAT_BYTES  = 8192;
	localparam int MAX_CHAIN  = 64;

	localparam int BANK_DEPTH = (FAT_BYTES + 1) / 2;
	localparam int BANK_AW    = $clog2(BANK_DEPTH);
	localparam int STEP_W     = $clog2(MAX_CHAIN + 1);

	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W     = $clog2(QDEPTH + 1);

	localparam logic        CMD_LOAD = 1'b0;
	localparam logic        CMD_WALK = 1'b1;

	localparam logic [11:0] END_MIN  = 12'hff8;
	localparam logic [11:0] BAD_MARK = 12'hff7;
	localparam logic [11:0] LINK_MIN = 12'd2;

	localparam logic [7:0]  SECTOR_BIAS_RST = 8'd31;

	localparam logic [2:0]  ST_MORE  = 3'd0;
	localparam logic [2:0]  ST_END   = 3'd1;
	localparam logic [2:0]  ST_BAD   = 3'd2;
	localparam logic [2:0]  ST_LINK  = 3'd3;
	localparam logic [2:0]  ST_LIMIT = 3'd4;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_WALK  = 2'd1,
		OP_SHORT = 2'd2
	} op_t;

	typedef struct packed {
		logic        cmd;
		logic [12:0] fat_index;
		logic [7:0]  fat_byte;
		logic [11:0] start_cluster;
	} in_item_t;

	typedef struct packed {
		logic [11:0] cluster;
		logic [12:0] sector;
		logic        cluster_valid;
		logic [2:0]  status;
		logic        last;
	} out_item_t;

	typedef struct packed {
		op_t         op;
		logic [12:0] addr;
		logic [7:0]  data;
		logic [11:0] start;
	} q_entry_t;

endpackage
`default_nettype wire

// ===== hw/rtl/fcw_ram.sv =====
`default_nettype none
module fcw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== hw/rtl/fcw_front.sv =====
`default_nettype none
module fcw_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire fcw_pkg::in_item_t in_data,
	output logic                   q_valid,
	output fcw_pkg::q_entry_t      q_entry,
	input  wire logic              q_pop
);

	fcw_pkg::q_entry_t               slot_q [fcw_pkg::QDEPTH];
	logic [fcw_pkg::QPTR_W-1:0]      wptr_q;
	logic [fcw_pkg::QPTR_W-1:0]      rptr_q;
	logic [fcw_pkg::QCNT_W-1:0]      cnt_q;
	fcw_pkg::q_entry_t               entry_w;
	logic                            keep_w;
	logic                            push_w;
	logic                            pop_w;

	assign in_stall = (cnt_q == fcw_pkg::QCNT_W'(fcw_pkg::QDEPTH));

	always_comb begin
		entry_w.addr  = in_data.fat_index;
		entry_w.data  = in_data.fat_byte;
		entry_w.start = in_data.start_cluster;
		if (in_data.cmd == fcw_pkg::CMD_LOAD) begin
			entry_w.op = fcw_pkg::OP_LOAD;
		end else if (in_data.start_cluster < fcw_pkg::LINK_MIN) begin
			entry_w.op = fcw_pkg::OP_SHORT;
		end else begin
			entry_w.op = fcw_pkg::OP_WALK;
		end
		keep_w = (in_data.cmd == fcw_pkg::CMD_WALK) ||
			({1'b0, in_data.fat_index} < 14'(fcw_pkg::FAT_BYTES));
	end

	assign push_w = in_valid && !in_stall && keep_w;
	assign pop_w  = q_pop && (cnt_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push_w) begin
				wptr_q <= (wptr_q == fcw_pkg::QPTR_W'(fcw_pkg::QDEPTH - 1)) ? '0 :
					wptr_q + 1'b1;
			end
			if (pop_w) begin
				rptr_q <= (rptr_q == fcw_pkg::QPTR_W'(fcw_pkg::QDEPTH - 1)) ? '0 :
					rptr_q + 1'b1;
			end
			if (push_w && !pop_w) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop_w && !push_w) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_w) begin
			slot_q[wptr_q] <= entry_w;
		end
	end

	assign q_valid = (cnt_q != '0);
	assign q_entry = slot_q[rptr_q];

endmodule
`default_nettype wire

// ===== hw/rtl/fcw_back.sv =====
`default_nettype none
module fcw_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [7:0]        sector_bias,
	input  wire logic              q_valid,
	input  wire fcw_pkg::q_entry_t q_entry,
	output logic                   q_pop,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output fcw_pkg::out_item_t     out_data
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RD   = 3'b010,
		S_EVAL = 3'b100
	} state_t;

	state_t                       state_q;
	state_t                       state_d;
	logic [11:0]                  cur_q;
	logic [fcw_pkg::STEP_W-1:0]   steps_q;
	logic                         out_valid_q;
	fcw_pkg::out_item_t           out_data_q;

	logic                         out_free_w;
	logic                         load_out_w;
	fcw_pkg::out_item_t           res_w;
	logic                         start_walk_w;
	logic                         step_w;

	logic [12:0]                  pos_w;
	logic [11:0]                  half_w;
	logic [fcw_pkg::BANK_AW-1:0]  raddr0_w;
	logic [fcw_pkg::BANK_AW-1:0]  raddr1_w;
	logic [7:0]                   rdata0_w;
	logic [7:0]                   rdata1_w;
	logic [7:0]                   lo_w;
	logic [7:0]                   hi_w;
	logic [11:0]                  entry_w;
	logic [2:0]                   status_w;

	logic                         we0_w;
	logic                         we1_w;
	logic [fcw_pkg::BANK_AW-1:0]  waddr_w;

	assign out_free_w = !out_valid_q || !out_stall;

	always_comb begin
		pos_w    = {1'b0, cur_q} + {2'b00, cur_q[11:1]};
		half_w   = pos_w[12:1];
		raddr1_w = fcw_pkg::BANK_AW'(half_w);
		raddr0_w = pos_w[0] ? fcw_pkg::BANK_AW'(half_w + 12'd1) :
			fcw_pkg::BANK_AW'(half_w);
		lo_w     = pos_w[0] ? rdata1_w : rdata0_w;
		hi_w     = pos_w[0] ? rdata0_w : rdata1_w;
		entry_w  = cur_q[0] ? {hi_w, lo_w[7:4]} : {hi_w[3:0], lo_w};
		priority if (entry_w >= fcw_pkg::END_MIN) begin
			status_w = fcw_pkg::ST_END;
		end else if (entry_w == fcw_pkg::BAD_MARK) begin
			status_w = fcw_pkg::ST_BAD;
		end else if (entry_w < fcw_pkg::LINK_MIN) begin
			status_w = fcw_pkg::ST_LINK;
		end else if (steps_q >= fcw_pkg::STEP_W'(fcw_pkg::MAX_CHAIN - 1)) begin
			status_w = fcw_pkg::ST_LIMIT;
		end else begin
			status_w = fcw_pkg::ST_MORE;
		end
	end

	always_comb begin
		state_d      = state_q;
		q_pop        = 1'b0;
		load_out_w   = 1'b0;
		start_walk_w = 1'b0;
		step_w       = 1'b0;
		we0_w        = 1'b0;
		we1_w        = 1'b0;
		waddr_w      = fcw_pkg::BANK_AW'(q_entry.addr[12:1]);
		res_w.cluster       = cur_q;
		res_w.sector        = {1'b0, cur_q} + {5'b00000, sector_bias};
		res_w.cluster_valid = 1'b1;
		res_w.status        = status_w;
		res_w.last          = (status_w != fcw_pkg::ST_MORE);
		unique case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					unique case (q_entry.op)
						fcw_pkg::OP_LOAD: begin
							q_pop = 1'b1;
							we0_w = !q_entry.addr[0];
							we1_w = q_entry.addr[0];
						end
						fcw_pkg::OP_SHORT: begin
							if (out_free_w) begin
								q_pop               = 1'b1;
								load_out_w          = 1'b1;
								res_w.cluster       = '0;
								res_w.sector        = '0;
								res_w.cluster_valid = 1'b0;
								res_w.status        = fcw_pkg::ST_LINK;
								res_w.last          = 1'b1;
							end
						end
						fcw_pkg::OP_WALK: begin
							q_pop        = 1'b1;
							start_walk_w = 1'b1;
							state_d      = S_RD;
						end
						default: begin
							q_pop = 1'b1;
						end
					endcase
				end
			end
			S_RD: begin
				state_d = S_EVAL;
			end
			S_EVAL: begin
				if (out_free_w) begin
					load_out_w = 1'b1;
					step_w     = 1'b1;
					state_d    = res_w.last ? S_IDLE : S_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			steps_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start_walk_w) begin
				steps_q <= '0;
			end else if (step_w) begin
				steps_q <= steps_q + 1'b1;
			end
			if (load_out_w) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_walk_w) begin
			cur_q <= q_entry.start;
		end else if (step_w) begin
			cur_q <= entry_w;
		end
		if (load_out_w) begin
			out_data_q <= res_w;
		end
	end

	fcw_ram #(
		.WIDTH(8),
		.DEPTH(fcw_pkg::BANK_DEPTH)
	) u_bank0 (
		.clk   (clk),
		.we    (we0_w),
		.waddr (waddr_w),
		.wdata (q_entry.data),
		.raddr (raddr0_w),
		.rdata (rdata0_w)
	);

	fcw_ram #(
		.WIDTH(8),
		.DEPTH(fcw_pkg::BANK_DEPTH)
	) u_bank1 (
		.clk   (clk),
		.we    (we1_w),
		.waddr (waddr_w),
		.wdata (q_entry.data),
		.raddr (raddr1_w),
		.rdata (rdata1_w)
	);

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
`default_nettype wire

// ===== hw/rtl/fat12_cluster_chain_walk_core.sv =====
// FAT12 cluster chain walker.
// The input channel (in_valid, in_stall, in_data) carries two kinds of transaction.
// A load writes one byte of the allocation table and gives no result; up to one load
// is taken per cycle while the two-entry command queue has room. A walk names a start
// cluster and yields one output transaction per cluster of the chain, the last one
// marked with last and a status that tells why the chain stopped.
// A walk's results come one per cluster: each cluster needs one read of the even and odd
// table banks (state S_RD) and a decode of the entry (state S_EVAL), and the next
// queued command waits until the walk ends. A start cluster below two gives a single
// result, registered in the cycle after it is taken; it is taken only when the block is
// idle and the output is free.
// The table is split into an even-byte bank and an odd-byte bank so that both
// bytes of an entry come from one read.
// cfg_wen and cfg_wdata write the sector bias; write it only while the block is idle.
// Reset empties the queue, drops any pending result and sets the bias to 31; the
// table contents are undefined until loaded.
// When out_stall is high the current result holds, the walk waits, and once the
// queue is full in_stall rises.
`default_nettype none
module fat12_cluster_chain_walk_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire fcw_pkg::in_item_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output fcw_pkg::out_item_t      out_data,
	input  wire logic               cfg_wen,
	input  wire logic [7:0]         cfg_wdata
);

	logic [7:0]         bias_q;
	logic               q_valid;
	fcw_pkg::q_entry_t  q_entry;
	logic               q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q <= fcw_pkg::SECTOR_BIAS_RST;
		end else if (cfg_wen) begin
			bias_q <= cfg_wdata;
		end
	end

	fcw_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.q_valid  (q_valid),
		.q_entry  (q_entry),
		.q_pop    (q_pop)
	);

	fcw_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.sector_bias (bias_q),
		.q_valid     (q_valid),
		.q_entry     (q_entry),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

	a_more_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.last |->
			out_data.cluster_valid && (out_data.status == fcw_pkg::ST_MORE))
		else $error("non-final result without a chain element");

	a_last_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.last |-> (out_data.status != fcw_pkg::ST_MORE))
		else $error("final result with status more");

	a_short_walk: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.cluster_valid |->
			out_data.last && (out_data.status == fcw_pkg::ST_LINK))
		else $error("empty result is not a short walk");

	a_sector: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.cluster_valid |->
			(out_data.sector == ({1'b0, out_data.cluster} + {5'b00000, bias_q})))
		else $error("sector does not match cluster plus bias");

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");

endmodule
`default_nettype wire
